@@ hw/rtl/bbc_pkg.sv @@
// Shared types, constants and helpers for the block buffer cache tag table.
// No dependencies; every other file in hw/rtl imports this package.
package bbc_pkg;

  // Table geometry
  localparam int NUM_BUFFERS = 16;
  localparam int IDX_W       = $clog2(NUM_BUFFERS);

  // Request op codes
  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_FILLED  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_NOBUF  = 3'd3;
  localparam logic [2:0] ST_RELERR = 3'd4;

  // Input request
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  device;
    logic [31:0] sector_num;
    logic [3:0]  slot_in;
  } bbc_req_t;

  // Result
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_out;
    logic       data_valid;
    logic       wake_waiters;
  } bbc_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the incoming request
    logic compare;   // register the tag match vector
    logic commit;    // update table state and load the result register
  } bbc_cmd_t;

  // Lowest set bit of a vector over all entries
  function automatic logic [IDX_W-1:0] first_set(input logic [NUM_BUFFERS-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/bbc_ctrl.sv @@
// Sequencer for the tag table: capture, compare and commit steps.
// Depends on bbc_pkg for the command struct.
module bbc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bbc_pkg::bbc_cmd_t cmd
);
  import bbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_r || out_ready;

  // A new request enters while idle or as the current one commits
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_UPD) && out_free);
  assign accept   = in_valid && in_ready;

  assign cmd.load_req = accept;
  assign cmd.compare  = (state_r == S_CMP);
  assign cmd.commit   = (state_r == S_UPD) && out_free;

  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) state_nxt = accept ? S_CMP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/bbc_dpath.sv @@
// Tag and flag storage, parallel tag compare, victim pick and result register.
// Depends on bbc_pkg; driven by commands from bbc_ctrl.
module bbc_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  bbc_pkg::bbc_cmd_t cmd,
  input  bbc_pkg::bbc_req_t in_req,
  output bbc_pkg::bbc_rsp_t out_rsp
);
  import bbc_pkg::*;

  localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W + 1)'(NUM_BUFFERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  logic [7:0]             tag_dev_r [NUM_BUFFERS];
  logic [31:0]            tag_sec_r [NUM_BUFFERS];
  logic [7:0]             tag_dev_nxt [NUM_BUFFERS];
  logic [31:0]            tag_sec_nxt [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] busy_r, busy_nxt;
  logic [NUM_BUFFERS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;
  bbc_req_t               req_r;
  logic [NUM_BUFFERS-1:0] match_r, match_nxt;
  bbc_rsp_t               rsp_r, rsp_nxt;

  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic [NUM_BUFFERS-1:0] free_vec;
  logic [NUM_BUFFERS-1:0] free_rot;
  logic [2*NUM_BUFFERS-1:0] free_dbl;
  logic                   free_any;
  logic [IDX_W-1:0]       free_ofs;
  logic [IDX_W:0]         cand_sum;
  logic [IDX_W-1:0]       cand;
  logic                   slot_ok;

  assign out_rsp = rsp_r;

  // Parallel tag compare against live entries
  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match_nxt[i] = (busy_r[i] || valid_r[i]) &&
                     (tag_dev_r[i] == req_r.device) &&
                     (tag_sec_r[i] == req_r.sector_num);
    end
  end

  // Hit pick: lowest matching entry
  assign hit_any = |match_r;
  assign hit_idx = first_set(match_r);

  // Victim pick: first free entry at or after the round-robin pointer
  assign free_vec = ~busy_r;
  assign free_any = |free_vec;
  assign free_dbl = {free_vec, free_vec} >> ptr_r;
  assign free_rot = free_dbl[NUM_BUFFERS-1:0];
  assign free_ofs = first_set(free_rot);
  assign cand_sum = {1'b0, ptr_r} + {1'b0, free_ofs};

  always_comb begin
    if (cand_sum >= SLOT_LIMIT) cand = IDX_W'(cand_sum - SLOT_LIMIT);
    else cand = cand_sum[IDX_W-1:0];
  end

  assign slot_ok = ({1'b0, req_r.slot_in} < SLOT_LIMIT);

  // Table update and result for the committed request
  always_comb begin
    busy_nxt    = busy_r;
    valid_nxt   = valid_r;
    ptr_nxt     = ptr_r;
    tag_dev_nxt = tag_dev_r;
    tag_sec_nxt = tag_sec_r;
    rsp_nxt     = '0;
    case (req_r.op)
      OP_GET: begin
        if (hit_any) begin
          if (busy_r[hit_idx]) begin
            rsp_nxt.status = ST_WAIT;
          end else begin
            busy_nxt[hit_idx]  = 1'b1;
            rsp_nxt.status     = ST_HIT;
            rsp_nxt.slot_out   = 4'(hit_idx);
            rsp_nxt.data_valid = valid_r[hit_idx];
          end
        end else if (free_any) begin
          busy_nxt[cand]    = 1'b1;
          valid_nxt[cand]   = 1'b0;
          tag_dev_nxt[cand] = req_r.device;
          tag_sec_nxt[cand] = req_r.sector_num;
          ptr_nxt           = (cand == LAST_IDX) ? '0 : cand + 1'b1;
          rsp_nxt.status    = ST_MISS;
          rsp_nxt.slot_out  = 4'(cand);
        end else begin
          rsp_nxt.status = ST_NOBUF;
        end
      end
      OP_RELEASE: begin
        if (slot_ok && busy_r[req_r.slot_in[IDX_W-1:0]]) begin
          busy_nxt[req_r.slot_in[IDX_W-1:0]] = 1'b0;
          rsp_nxt.status       = ST_HIT;
          rsp_nxt.wake_waiters = 1'b1;
        end else begin
          rsp_nxt.status = ST_RELERR;
        end
      end
      OP_FILLED: begin
        if (slot_ok) valid_nxt[req_r.slot_in[IDX_W-1:0]] = 1'b1;
      end
      default: begin
        rsp_nxt = '0;
      end
    endcase
  end

  // Request capture, compare result and result register
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_req;
    if (cmd.compare) match_r <= match_nxt;
    if (cmd.commit) rsp_r <= rsp_nxt;
  end

  // Table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      valid_r <= '0;
      ptr_r   <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev_r[i] <= '0;
        tag_sec_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      busy_r    <= busy_nxt;
      valid_r   <= valid_nxt;
      ptr_r     <= ptr_nxt;
      tag_dev_r <= tag_dev_nxt;
      tag_sec_r <= tag_sec_nxt;
    end
  end

endmodule

@@ hw/rtl/block_buffer_cache_tags.sv @@
// Block buffer cache tag table: top level joining sequencer and datapath.
// Depends on bbc_pkg, bbc_ctrl and bbc_dpath.
//
// Usage:
//   in_valid/in_ready/in_req carry one request: get block (device, sector),
//   release slot, or mark slot filled. out_valid/out_ready/out_rsp return
//   exactly one result per request, in request order.
//   After acceptance each request passes the compare step, which registers
//   the 16-way tag compare, and then the commit step, which picks the hit or
//   the round-robin victim, updates the busy/valid marks and loads the result
//   register. Requests go one at a time through the compare/commit sequence
//   on the shared table; a new request is taken in the same cycle that the
//   previous one commits.
//   If the receiver stalls, a finished result holds in the output register;
//   one more request may be accepted and compared, then it waits to commit
//   until the result register frees up.
//   Synchronous reset (rst_n low) clears all busy/valid marks, tags and the
//   victim pointer, and drops out_valid.
module block_buffer_cache_tags (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbc_pkg::bbc_req_t in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output bbc_pkg::bbc_rsp_t out_rsp
);
  import bbc_pkg::*;

  bbc_cmd_t cmd;

  bbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bbc_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

@@ hw/rtl/bbc_checker.sv @@
// Port-level checks for the block buffer cache tag table, bound to the top.
// Depends on bbc_pkg for status codes and payload types.
module bbc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bbc_pkg::bbc_rsp_t out_rsp
);
  import bbc_pkg::*;

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // Only a granted or allocated slot reports a slot or valid data
  a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_HIT) && (out_rsp.status != ST_MISS)
    |-> (out_rsp.slot_out == '0) && !out_rsp.data_valid && !out_rsp.wake_waiters)
    else $error("non-grant result carries slot or flags");

  // Wakeup only on a clean release
  a_wake_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.wake_waiters
    |-> (out_rsp.status == ST_HIT) && (out_rsp.slot_out == '0) && !out_rsp.data_valid)
    else $error("wakeup with bad result fields");

  // A freshly allocated slot never claims valid data
  a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_MISS) |-> !out_rsp.data_valid)
    else $error("miss reported valid data");

endmodule

bind block_buffer_cache_tags bbc_checker u_bbc_checker (.*);
